FILE: sv/arbrb_pkg.sv
package arbrb_pkg;

    localparam int CAPACITY    = 1024;
    localparam int BLOCK_BYTES = 512;

    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int LEVEL_W     = $clog2(CAPACITY + 1);
    localparam int WORD_BYTES  = 8;
    localparam int WORD_W      = 8 * WORD_BYTES;
    localparam int LANE_W      = $clog2(WORD_BYTES);
    localparam int ISSUE_W     = $clog2(BLOCK_BYTES + 1);
    localparam int LINE_BYTES  = 7;
    localparam int LINE_IDX_W  = $clog2(LINE_BYTES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // func codes on the input channel
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_GET   = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_LF    = 8'h0A;

    // byte positions within one text line
    localparam logic [LINE_IDX_W-1:0] POS_HDR   = LINE_IDX_W'(0);
    localparam logic [LINE_IDX_W-1:0] POS_SPACE = LINE_IDX_W'(1);
    localparam logic [LINE_IDX_W-1:0] POS_HUND  = LINE_IDX_W'(2);
    localparam logic [LINE_IDX_W-1:0] POS_TENS  = LINE_IDX_W'(3);
    localparam logic [LINE_IDX_W-1:0] POS_UNITS = LINE_IDX_W'(4);
    localparam logic [LINE_IDX_W-1:0] POS_CR    = LINE_IDX_W'(5);
    localparam logic [LINE_IDX_W-1:0] POS_LF    = LINE_IDX_W'(6);

    typedef enum logic [1:0] {
        OP_PUT,
        OP_GET,
        OP_FLUSH,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] hdr;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
    } t_cmd;

endpackage

FILE: sv/arbrb_ram.sv
module arbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/arbrb_front.sv
module arbrb_front (
    input  logic [1:0]      i_func,
    input  logic [7:0]      i_reading,
    input  logic [3:0]      i_sensor_id,
    output arbrb_pkg::t_cmd o_cmd
);

    logic [1:0]  w_hund;
    logic [6:0]  w_rem;
    logic [14:0] w_tens_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_units;

    // split the reading into decimal digits
    always_comb begin
        if (i_reading >= 8'd200) begin
            w_hund = 2'd2;
        end else if (i_reading >= 8'd100) begin
            w_hund = 2'd1;
        end else begin
            w_hund = 2'd0;
        end
        w_rem       = 7'(i_reading - 8'(w_hund) * 8'd100);
        // divide by ten: exact for values below one hundred
        w_tens_prod = 15'(w_rem) * 15'd205;
        w_tens      = w_tens_prod[14:11];
        w_units     = w_rem - 7'(w_tens) * 7'd10;
    end

    always_comb begin
        case (i_func)
            arbrb_pkg::FUNC_PUT:   o_cmd.op = arbrb_pkg::OP_PUT;
            arbrb_pkg::FUNC_GET:   o_cmd.op = arbrb_pkg::OP_GET;
            arbrb_pkg::FUNC_FLUSH: o_cmd.op = arbrb_pkg::OP_FLUSH;
            default:               o_cmd.op = arbrb_pkg::OP_NOP;
        endcase
        o_cmd.hdr   = arbrb_pkg::ASCII_ZERO + 8'(i_sensor_id);
        o_cmd.hund  = 4'(w_hund);
        o_cmd.tens  = w_tens;
        o_cmd.units = w_units[3:0];
    end

endmodule

FILE: sv/arbrb_queue.sv
module arbrb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  arbrb_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output arbrb_pkg::t_cmd o_cmd
);

    arbrb_pkg::t_cmd                 r_mem [arbrb_pkg::QUEUE_DEPTH];
    logic [arbrb_pkg::QIDX_W-1:0]    r_wr_idx;
    logic [arbrb_pkg::QIDX_W-1:0]    r_rd_idx;
    logic [arbrb_pkg::QCNT_W-1:0]    r_count;
    logic                            w_push;
    logic                            w_pop;

    assign o_full  = (r_count == arbrb_pkg::QCNT_W'(arbrb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_idx];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wr_idx] <= i_cmd;
                r_wr_idx <= (r_wr_idx == arbrb_pkg::QIDX_W'(arbrb_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_idx + 1'b1;
            end
            if (w_pop) begin
                r_rd_idx <= (r_rd_idx == arbrb_pkg::QIDX_W'(arbrb_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_idx + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/arbrb_back.sv
module arbrb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  arbrb_pkg::t_cmd               i_cmd,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [arbrb_pkg::WORD_W-1:0]  o_data_word,
    output logic                          o_block_ok,
    output logic [arbrb_pkg::LEVEL_W-1:0] o_level,
    output logic                          o_empty_res,
    output logic                          o_overflow,
    output logic                          o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUT,
        S_GET_RD,
        S_GET_PUSH
    } t_state;

    t_state                              r_state;
    logic [arbrb_pkg::LEVEL_W-1:0]       r_fill;
    logic [arbrb_pkg::ADDR_W-1:0]        r_wr_ptr;
    logic [arbrb_pkg::ADDR_W-1:0]        r_rd_ptr;
    arbrb_pkg::t_cmd                     r_cmd;
    logic [arbrb_pkg::LINE_IDX_W-1:0]    r_put_idx;
    logic [arbrb_pkg::ISSUE_W-1:0]       r_issued;
    logic [arbrb_pkg::LANE_W-1:0]        r_lane;
    logic [arbrb_pkg::LANE_W-1:0]        r_rd_lane;
    logic                                r_rd_pend;
    logic [arbrb_pkg::WORD_W-1:0]        r_word;

    logic                                r_out_valid;
    logic [arbrb_pkg::WORD_W-1:0]        r_out_word;
    logic                                r_out_ok;
    logic [arbrb_pkg::LEVEL_W-1:0]       r_out_level;
    logic                                r_out_empty;
    logic                                r_out_ovf;
    logic                                r_out_last;

    logic                                w_out_free;
    logic                                w_room;
    logic                                w_block;
    logic                                w_load;
    logic [arbrb_pkg::WORD_W-1:0]        w_ld_word;
    logic                                w_ld_ok;
    logic [arbrb_pkg::LEVEL_W-1:0]       w_ld_level;
    logic                                w_ld_ovf;
    logic                                w_ld_last;
    logic                                w_block_done;
    logic [7:0]                          w_put_byte;
    logic [7:0]                          w_ram_q;
    logic [arbrb_pkg::ADDR_W-1:0]        w_wr_ptr_inc;
    logic [arbrb_pkg::ADDR_W-1:0]        w_rd_ptr_inc;

    arbrb_ram #(
        .WIDTH (8),
        .DEPTH (arbrb_pkg::CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PUT),
        .i_waddr (r_wr_ptr),
        .i_wdata (w_put_byte),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_ram_q)
    );

    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_room       = (r_fill <= arbrb_pkg::LEVEL_W'(arbrb_pkg::CAPACITY
                                                          - arbrb_pkg::LINE_BYTES));
    assign w_block      = (r_fill >= arbrb_pkg::LEVEL_W'(arbrb_pkg::BLOCK_BYTES));
    assign w_block_done = (r_issued == arbrb_pkg::ISSUE_W'(arbrb_pkg::BLOCK_BYTES));
    assign o_pop        = (r_state == S_IDLE) && i_cmd_valid && w_out_free;

    assign w_wr_ptr_inc = (r_wr_ptr == arbrb_pkg::ADDR_W'(arbrb_pkg::CAPACITY - 1))
                        ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_ptr_inc = (r_rd_ptr == arbrb_pkg::ADDR_W'(arbrb_pkg::CAPACITY - 1))
                        ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        case (r_put_idx)
            arbrb_pkg::POS_HDR:   w_put_byte = r_cmd.hdr;
            arbrb_pkg::POS_SPACE: w_put_byte = arbrb_pkg::ASCII_SPACE;
            arbrb_pkg::POS_HUND:  w_put_byte = arbrb_pkg::ASCII_ZERO + 8'(r_cmd.hund);
            arbrb_pkg::POS_TENS:  w_put_byte = arbrb_pkg::ASCII_ZERO + 8'(r_cmd.tens);
            arbrb_pkg::POS_UNITS: w_put_byte = arbrb_pkg::ASCII_ZERO + 8'(r_cmd.units);
            arbrb_pkg::POS_CR:    w_put_byte = arbrb_pkg::ASCII_CR;
            default:              w_put_byte = arbrb_pkg::ASCII_LF;
        endcase
    end

    // result to place in the output register this cycle
    always_comb begin
        w_load     = 1'b0;
        w_ld_word  = '0;
        w_ld_ok    = 1'b0;
        w_ld_level = r_fill;
        w_ld_ovf   = 1'b0;
        w_ld_last  = 1'b1;
        if (o_pop) begin
            w_load = 1'b1;
            case (i_cmd.op)
                arbrb_pkg::OP_PUT: begin
                    if (w_room) begin
                        w_ld_level = r_fill + arbrb_pkg::LEVEL_W'(arbrb_pkg::LINE_BYTES);
                    end else begin
                        w_ld_ovf = 1'b1;
                    end
                end
                arbrb_pkg::OP_GET: begin
                    // a full block is reported word by word later
                    w_load = !w_block;
                end
                arbrb_pkg::OP_FLUSH: begin
                    w_ld_level = '0;
                end
                default: begin
                    w_ld_level = r_fill;
                end
            endcase
        end else if (r_state == S_GET_PUSH && !r_rd_pend && w_out_free) begin
            w_load    = 1'b1;
            w_ld_word = r_word;
            w_ld_ok   = 1'b1;
            w_ld_last = w_block_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_word  <= w_ld_word;
                r_out_ok    <= w_ld_ok;
                r_out_level <= w_ld_level;
                r_out_empty <= (w_ld_level == '0);
                r_out_ovf   <= w_ld_ovf;
                r_out_last  <= w_ld_last;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            // land the byte read in the previous cycle
            r_rd_pend <= (r_state == S_GET_RD);
            if (r_rd_pend) begin
                r_word[{r_rd_lane, 3'b000} +: 8] <= w_ram_q;
            end

            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.op)
                            arbrb_pkg::OP_PUT: begin
                                if (w_room) begin
                                    r_fill    <= r_fill
                                               + arbrb_pkg::LEVEL_W'(arbrb_pkg::LINE_BYTES);
                                    r_put_idx <= arbrb_pkg::POS_HDR;
                                    r_state   <= S_PUT;
                                end
                            end
                            arbrb_pkg::OP_GET: begin
                                if (w_block) begin
                                    r_fill   <= r_fill
                                              - arbrb_pkg::LEVEL_W'(arbrb_pkg::BLOCK_BYTES);
                                    r_issued <= '0;
                                    r_lane   <= '0;
                                    r_word   <= '0;
                                    r_state  <= S_GET_RD;
                                end
                            end
                            arbrb_pkg::OP_FLUSH: begin
                                r_fill   <= '0;
                                r_wr_ptr <= '0;
                                r_rd_ptr <= '0;
                            end
                            default: begin
                                r_fill <= r_fill;
                            end
                        endcase
                    end
                end
                S_PUT: begin
                    r_wr_ptr <= w_wr_ptr_inc;
                    if (r_put_idx == arbrb_pkg::POS_LF) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_put_idx <= r_put_idx + 1'b1;
                    end
                end
                S_GET_RD: begin
                    r_rd_ptr  <= w_rd_ptr_inc;
                    r_issued  <= r_issued + 1'b1;
                    r_rd_lane <= r_lane;
                    r_lane    <= r_lane + 1'b1;
                    if (r_lane == arbrb_pkg::LANE_W'(arbrb_pkg::WORD_BYTES - 1)
                        || r_issued == arbrb_pkg::ISSUE_W'(arbrb_pkg::BLOCK_BYTES - 1)) begin
                        r_state <= S_GET_PUSH;
                    end
                end
                S_GET_PUSH: begin
                    if (!r_rd_pend && w_out_free) begin
                        // clear so a short final word is zero padded
                        r_word  <= '0;
                        r_lane  <= '0;
                        r_state <= w_block_done ? S_IDLE : S_GET_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data_word = r_out_word;
    assign o_block_ok  = r_out_ok;
    assign o_level     = r_out_level;
    assign o_empty_res = r_out_empty;
    assign o_overflow  = r_out_ovf;
    assign o_last      = r_out_last;

endmodule

FILE: sv/ascii_reading_block_ring_buffer_unit.sv
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_func, i_reading, i_sensor_id
// output    out        o_valid / i_stall   o_data_word, o_block_ok, o_level,
//                                          o_empty_res, o_overflow, o_last
//
// A put in the back end is dispatched, then makes seven byte writes into the
// byte store, which has one write port and one read port. A get of a full
// block reads each word as eight byte reads plus a hand-off; the one byte-wide
// read port limits it. Other items give their result on dispatch.
// Reset (i_rst_n low, synchronous) clears pointers, count and queue; the byte
// store is not cleared. A two-entry queue takes items while the back end works;
// i_stall holds the output register and the back end's dispatch and word hand-off.
module ascii_reading_block_ring_buffer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_func,
    input  logic [7:0]                    i_reading,
    input  logic [3:0]                    i_sensor_id,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [arbrb_pkg::WORD_W-1:0]  o_data_word,
    output logic                          o_block_ok,
    output logic [arbrb_pkg::LEVEL_W-1:0] o_level,
    output logic                          o_empty_res,
    output logic                          o_overflow,
    output logic                          o_last
);

    arbrb_pkg::t_cmd w_in_cmd;
    arbrb_pkg::t_cmd w_q_cmd;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_pop;

    arbrb_front u_front (
        .i_func      (i_func),
        .i_reading   (i_reading),
        .i_sensor_id (i_sensor_id),
        .o_cmd       (w_in_cmd)
    );

    arbrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_cmd   (w_in_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    arbrb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data_word (o_data_word),
        .o_block_ok  (o_block_ok),
        .o_level     (o_level),
        .o_empty_res (o_empty_res),
        .o_overflow  (o_overflow),
        .o_last      (o_last)
    );

    assign o_stall = w_q_full;

endmodule

FILE: sv/arbrb_checker.sv
module arbrb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [arbrb_pkg::WORD_W-1:0]  o_data_word,
    input logic                          o_block_ok,
    input logic [arbrb_pkg::LEVEL_W-1:0] o_level,
    input logic                          o_empty_res,
    input logic                          o_overflow,
    input logic                          o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_word) && $stable(o_last))
        else $error("stalled item changed");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_empty_res == (o_level == '0)))
        else $error("empty flag disagrees with level");

    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_block_ok |-> (o_data_word == '0) && o_last)
        else $error("non-block item carries data");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> !o_block_ok
            && (o_level > arbrb_pkg::LEVEL_W'(arbrb_pkg::CAPACITY - arbrb_pkg::LINE_BYTES)))
        else $error("overflow reported with room left");

    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level <= arbrb_pkg::LEVEL_W'(arbrb_pkg::CAPACITY)))
        else $error("level beyond capacity");

endmodule

bind ascii_reading_block_ring_buffer_unit arbrb_checker u_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int WORDS_PER_BLOCK = (arbrb_pkg::BLOCK_BYTES + arbrb_pkg::WORD_BYTES - 1)
                                   / arbrb_pkg::WORD_BYTES;
    localparam int TOTAL_ITEMS     = 450;
    localparam int TAIL_CYCLES     = 800;
    localparam logic [1:0] FUNC_SPARE = arbrb_pkg::OP_NOP;

    typedef struct packed {
        logic [arbrb_pkg::WORD_W-1:0]  word;
        logic                          ok;
        logic [arbrb_pkg::LEVEL_W-1:0] level;
        logic                          empty;
        logic                          ovf;
        logic                          last;
    } t_log_result;

    typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} t_rx_mode;

    // Tracks the text ring and the results each accepted item should produce.
    class text_log_board;
        bit [7:0]    text_bytes [arbrb_pkg::CAPACITY];
        int          head;
        int          tail;
        int          fill;
        t_log_result pending_results [$];
        int          error_count;
        int          puts;
        int          drops;
        int          blocks;
        int          short_gets;
        int          flushes;
        int          spare_items;
        int          words_seen;

        function void note_item(logic [1:0] func, logic [7:0] reading, logic [3:0] sensor);
            t_log_result                  res;
            logic [7:0]                   text_line [arbrb_pkg::LINE_BYTES];
            logic [arbrb_pkg::WORD_W-1:0] block_word [WORDS_PER_BLOCK];
            int                           w;
            int                           b;
            int                           idx;
            res      = '0;
            res.last = 1'b1;
            case (arbrb_pkg::t_op'(func))
                arbrb_pkg::OP_PUT: begin
                    if (arbrb_pkg::CAPACITY - fill < arbrb_pkg::LINE_BYTES) begin
                        res.ovf = 1'b1;
                        drops++;
                    end else begin
                        text_line[arbrb_pkg::POS_HDR]   = arbrb_pkg::ASCII_ZERO + 8'(sensor);
                        text_line[arbrb_pkg::POS_SPACE] = arbrb_pkg::ASCII_SPACE;
                        text_line[arbrb_pkg::POS_HUND]  = arbrb_pkg::ASCII_ZERO
                                                        + 8'(reading / 100);
                        text_line[arbrb_pkg::POS_TENS]  = arbrb_pkg::ASCII_ZERO
                                                        + 8'((reading / 10) % 10);
                        text_line[arbrb_pkg::POS_UNITS] = arbrb_pkg::ASCII_ZERO
                                                        + 8'(reading % 10);
                        text_line[arbrb_pkg::POS_CR]    = arbrb_pkg::ASCII_CR;
                        text_line[arbrb_pkg::POS_LF]    = arbrb_pkg::ASCII_LF;
                        for (b = 0; b < arbrb_pkg::LINE_BYTES; b++) begin
                            text_bytes[head] = text_line[b];
                            head = (head + 1) % arbrb_pkg::CAPACITY;
                        end
                        fill += arbrb_pkg::LINE_BYTES;
                        puts++;
                    end
                end
                arbrb_pkg::OP_GET: begin
                    if (fill < arbrb_pkg::BLOCK_BYTES) begin
                        short_gets++;
                    end else begin
                        // pad the tail of a partial last word with zero bytes
                        for (w = 0; w < WORDS_PER_BLOCK; w++) begin
                            block_word[w] = '0;
                            for (b = 0; b < arbrb_pkg::WORD_BYTES; b++) begin
                                idx = w * arbrb_pkg::WORD_BYTES + b;
                                if (idx < arbrb_pkg::BLOCK_BYTES)
                                    block_word[w][8*b +: 8] =
                                        text_bytes[(tail + idx) % arbrb_pkg::CAPACITY];
                            end
                        end
                        tail = (tail + arbrb_pkg::BLOCK_BYTES) % arbrb_pkg::CAPACITY;
                        fill -= arbrb_pkg::BLOCK_BYTES;
                        blocks++;
                        for (w = 0; w < WORDS_PER_BLOCK; w++) begin
                            res.word  = block_word[w];
                            res.ok    = 1'b1;
                            res.level = arbrb_pkg::LEVEL_W'(fill);
                            res.empty = (fill == 0);
                            res.ovf   = 1'b0;
                            res.last  = (w == WORDS_PER_BLOCK - 1);
                            pending_results.push_back(res);
                        end
                        return;
                    end
                end
                arbrb_pkg::OP_FLUSH: begin
                    head = 0;
                    tail = 0;
                    fill = 0;
                    flushes++;
                end
                default: begin
                    spare_items++;
                end
            endcase
            res.level = arbrb_pkg::LEVEL_W'(fill);
            res.empty = (fill == 0);
            pending_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [arbrb_pkg::WORD_W-1:0] want,
                                    logic [arbrb_pkg::WORD_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                error_count++;
            end
        endfunction

        function void check_result(t_log_result got);
            t_log_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: data_word %0h last %0b",
                       got.word, got.last);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            words_seen++;
            compare_field("data_word", want.word,  got.word);
            compare_field("block_ok",  want.ok,    got.ok);
            compare_field("level",     want.level, got.level);
            compare_field("empty_res", want.empty, got.empty);
            compare_field("overflow",  want.ovf,   got.ovf);
            compare_field("last",      want.last,  got.last);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_stall;
    logic [1:0]                    i_func      = arbrb_pkg::FUNC_PUT;
    logic [7:0]                    i_reading   = 8'd0;
    logic [3:0]                    i_sensor_id = 4'd0;
    logic                          o_valid;
    logic                          i_stall     = 1'b0;
    logic [arbrb_pkg::WORD_W-1:0]  o_data_word;
    logic                          o_block_ok;
    logic [arbrb_pkg::LEVEL_W-1:0] o_level;
    logic                          o_empty_res;
    logic                          o_overflow;
    logic                          o_last;

    text_log_board board = new();

    int       items_sent;
    int       burst_left;
    int       stall_left;
    int       stall_phase;
    t_rx_mode stall_mode;
    logic [7:0] stall_mask;
    int       round_len;
    int       roll;

    ascii_reading_block_ring_buffer_unit u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // note accepted items first so a result never races its own prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                board.note_item(i_func, i_reading, i_sensor_id);
            if (o_valid && !i_stall)
                board.check_result(t_log_result'({o_data_word, o_block_ok, o_level,
                                                  o_empty_res, o_overflow, o_last}));
        end
    end

    // receiver backpressure: free runs, random stalls, and a repeating mask
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_rx_mode'($urandom_range(0, 2));
            stall_left = $urandom_range(16, 256);
            stall_mask = 8'($urandom) & 8'hFE;
        end
        stall_left--;
        stall_phase = (stall_phase + 1) % 8;
        case (stall_mode)
            RX_FREE:   i_stall <= 1'b0;
            RX_RANDOM: i_stall <= ($urandom_range(0, 2) == 0);
            default:   i_stall <= stall_mask[stall_phase];
        endcase
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [1:0] func, input logic [7:0] reading,
                             input logic [3:0] sensor);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_func      <= func;
        i_reading   <= reading;
        i_sensor_id <= sensor;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [3:0] pick_sensor();
        return ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9));
    endfunction

    task automatic send_put();
        send_item(arbrb_pkg::FUNC_PUT, 8'($urandom_range(0, 255)), pick_sensor());
    endtask

    task automatic send_other(input logic [1:0] func);
        send_item(func, 8'($urandom), 4'($urandom));
    endtask

    // hold the sender off until every expected result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty ring, spare code, digit extremes, high sensor numbers
        send_item(arbrb_pkg::FUNC_GET,   8'd0,   4'd0);
        send_item(FUNC_SPARE,            8'd0,   4'd0);
        send_item(arbrb_pkg::FUNC_FLUSH, 8'd0,   4'd0);
        send_item(arbrb_pkg::FUNC_PUT,   8'd0,   4'd0);
        send_item(arbrb_pkg::FUNC_PUT,   8'd255, 4'd9);
        send_item(arbrb_pkg::FUNC_PUT,   8'd9,   4'd15);
        send_item(arbrb_pkg::FUNC_PUT,   8'd10,  4'd10);
        send_item(arbrb_pkg::FUNC_PUT,   8'd99,  4'd1);
        send_item(arbrb_pkg::FUNC_PUT,   8'd100, 4'd5);
        send_item(arbrb_pkg::FUNC_PUT,   8'd128, 4'd7);
        send_item(arbrb_pkg::FUNC_GET,   8'd255, 4'd15);
        send_item(FUNC_SPARE,            8'd255, 4'd15);
        send_item(arbrb_pkg::FUNC_FLUSH, 8'd170, 4'd3);
        send_item(arbrb_pkg::FUNC_GET,   8'd0,   4'd0);
        send_item(arbrb_pkg::FUNC_PUT,   8'd200, 4'd3);
        wait_drained();

        // fill past capacity so drops happen, then read a block out
        send_other(arbrb_pkg::FUNC_FLUSH);
        repeat (150) send_put();
        repeat (3) send_other(arbrb_pkg::FUNC_GET);
        wait_drained();

        while (items_sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    round_len = $urandom_range(40, 150);
                    if (round_len > TOTAL_ITEMS - items_sent)
                        round_len = TOTAL_ITEMS - items_sent;
                    repeat (round_len) begin
                        if ($urandom_range(0, 9) == 0)
                            send_other($urandom_range(0, 1) ? arbrb_pkg::FUNC_GET
                                                            : FUNC_SPARE);
                        else
                            send_put();
                    end
                    repeat ($urandom_range(1, 3)) send_other(arbrb_pkg::FUNC_GET);
                end
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        wait_drained();
                    repeat (20) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 70)
                            send_put();
                        else if (roll < 85)
                            send_other(arbrb_pkg::FUNC_GET);
                        else if (roll < 95)
                            send_other(FUNC_SPARE);
                        else
                            send_other(arbrb_pkg::FUNC_FLUSH);
                    end
                end
            endcase
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("run: %0d items, %0d lines logged, %0d dropped on a full ring, %0d blocks read",
                 items_sent, board.puts, board.drops, board.blocks);
        $display("run: %0d short gets, %0d flushes, %0d spare-code items, %0d results checked",
                 board.short_gets, board.flushes, board.spare_items, board.words_seen);
        if (board.error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: files.f
sv/arbrb_pkg.sv
sv/arbrb_ram.sv
sv/arbrb_front.sv
sv/arbrb_queue.sv
sv/arbrb_back.sv
sv/ascii_reading_block_ring_buffer_unit.sv
sv/arbrb_checker.sv
tb/sv/tb.sv
